### sv/stsel_pkg.sv
// Package for the scale tone selector: constants, codes, FSM states and cell control.
// No dependencies.
`default_nettype none
package stsel_pkg;

  localparam int DEF_OCTAVES = 5;
  localparam int SEMIS_PER_OCT = 12;

  localparam logic [6:0] NO_SEL_PITCH = 7'd24;
  localparam logic [6:0] LAST_PITCH_RST = 7'd127;
  localparam logic [3:0] MAX_BASE = 4'd11;

  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_TOGGLE = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [1:0] RANGE_ALL = 2'd0;
  localparam logic [1:0] RANGE_INNER = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_CALC,
    ST_PICK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage
`default_nettype wire

### sv/stsel_cell.sv
// One tone cell: holds the on/off bit of one semitone, rotates it to its neighbor.
// Depends on stsel_pkg.
`default_nettype none
module stsel_cell (
  input  wire                   clk,
  input  wire                   rst,
  input  stsel_pkg::cell_ctl_t  ctl,
  input  wire                   toggle_hit,
  input  wire                   d,
  output logic                  q
);
  import stsel_pkg::*;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      q <= 1'b0;
    end else if (toggle_hit) begin
      q <= ~q;
    end else if (ctl.shift) begin
      q <= d;
    end
  end

endmodule
`default_nettype wire

### sv/scale_tone_selector_top.sv
// Scale tone selector top: ring of tone cells plus the count/pick sequencer.
// Depends on stsel_pkg and stsel_cell.
// Each request passes through ST_COUNT, ST_CALC, ST_PICK and ST_DONE: the ring rotates once to
// count in-range tones, once more to find the picked tone; the result is loaded into
// m_tdata in ST_DONE when the output slot is free.
// A new request is taken in the cycle after the result is loaded, even while it waits.
// Synchronous reset clears all tones, range_mode to 0 and the last pitch to 127.
`default_nettype none
module scale_tone_selector_top #(
  parameter int OCTAVES = stsel_pkg::DEF_OCTAVES
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_wdata,      // range_mode
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [31:0] s_tdata,        // action[1:0], toggle_tone[9:2], signal_position[21:10],
                                      // signal_present[22], base_tone[26:23], zero[31:27]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [23:0] m_tdata         // pitch_semitones[6:0], selected[7], selected_tone[13:8],
                                      // active_count[19:14], changed[20], zero[23:21]
);
  import stsel_pkg::*;

  localparam int NTONES = OCTAVES * SEMIS_PER_OCT;
  localparam int IDXW = $clog2(NTONES);
  localparam int CNTW = $clog2(NTONES + 1);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NTONES - 1);
  localparam logic [IDXW-1:0] LO_INNER = IDXW'(SEMIS_PER_OCT);
  localparam logic [IDXW-1:0] LO_MID = IDXW'(2 * SEMIS_PER_OCT);
  localparam logic [IDXW-1:0] HI_INNER = IDXW'(NTONES - 1 - SEMIS_PER_OCT);
  localparam logic [IDXW-1:0] HI_MID = IDXW'(NTONES - 1 - 2 * SEMIS_PER_OCT);

  state_t state, state_next;
  cell_ctl_t ctl;

  logic [1:0]       range_mode;
  logic [11:0]      pos;
  logic             present;
  logic [3:0]       base;
  logic [IDXW-1:0]  step;
  logic [CNTW-1:0]  count;
  logic [CNTW-1:0]  pick;
  logic [CNTW-1:0]  seen;
  logic [IDXW-1:0]  sel;
  logic             have;
  logic [6:0]       last_pitch;

  logic [NTONES-1:0] tone;
  logic              accept;
  logic [1:0]        in_action;
  logic [7:0]        in_toggle;
  logic [IDXW-1:0]   lo, hi;
  logic              head_hit;
  logic [CNTW+11:0]  product;
  logic [3:0]        base_sat;
  logic [6:0]        pitch;
  logic [5:0]        count_sat;
  logic              load_out;

  assign accept = s_tvalid && s_tready;
  assign in_action = s_tdata[1:0];
  assign in_toggle = s_tdata[9:2];

  for (genvar i = 0; i < NTONES; i++) begin : g_cell
    localparam int NXT = (i + 1) % NTONES;
    logic hit;
    assign hit = accept && (in_action == ACT_TOGGLE) && !in_toggle[7]
                 && (in_toggle[6:0] == 7'(i));
    stsel_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .toggle_hit (hit),
      .d          (tone[NXT]),
      .q          (tone[i])
    );
  end

  always_comb begin
    case (range_mode)
      RANGE_ALL: begin
        lo = '0;
        hi = LAST_IDX;
      end
      RANGE_INNER: begin
        lo = LO_INNER;
        hi = HI_INNER;
      end
      default: begin
        lo = LO_MID;
        hi = HI_MID;
      end
    endcase
  end

  assign head_hit = tone[0] && (step >= lo) && (step <= hi);
  assign product = CNTW'(count) * 12'(pos);
  assign base_sat = (base > MAX_BASE) ? MAX_BASE : base;
  assign pitch = have ? (7'(sel) + 7'(base_sat)) : NO_SEL_PITCH;
  assign count_sat = (CNTW'(count) > CNTW'(63)) ? 6'd63 : 6'(count);
  assign load_out = (state == ST_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = ST_COUNT;
      ST_COUNT: if (step == LAST_IDX) state_next = ST_CALC;
      ST_CALC:  state_next = ST_PICK;
      ST_PICK:  if (step == LAST_IDX) state_next = ST_DONE;
      ST_DONE:  if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
    ctl.shift = (state == ST_COUNT) || (state == ST_PICK);
    ctl.clear = accept && (in_action == ACT_CLEAR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      range_mode <= RANGE_ALL;
      last_pitch <= LAST_PITCH_RST;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) range_mode <= cfg_wdata;
      if (load_out) begin
        m_tvalid <= 1'b1;
        last_pitch <= pitch;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos <= s_tdata[21:10];
      present <= s_tdata[22];
      base <= s_tdata[26:23];
      step <= '0;
      count <= '0;
    end
    case (state)
      ST_COUNT: begin
        step <= (step == LAST_IDX) ? '0 : step + 1'b1;
        if (head_hit) count <= count + 1'b1;
      end
      ST_CALC: begin
        pick <= product[CNTW+11:12];
        seen <= '0;
        sel <= '0;
        have <= 1'b0;
      end
      ST_PICK: begin
        step <= (step == LAST_IDX) ? '0 : step + 1'b1;
        if (head_hit && present) begin
          if (seen == pick && !have) begin
            sel <= step;
            have <= 1'b1;
          end
          seen <= seen + 1'b1;
        end
      end
      default: ;
    endcase
    if (load_out) begin
      m_tdata <= {3'b000, (pitch != last_pitch), count_sat, 6'(sel), have, pitch};
    end
  end

endmodule
`default_nettype wire

### bench/stsel_checker.sv
// Scoreboard for the scale tone selector: tracks range writes and accepted requests,
// predicts each result and compares it with the result stream. Depends on stsel_pkg.
module stsel_checker #(
  parameter int OCTAVES = stsel_pkg::DEF_OCTAVES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import stsel_pkg::*;

  localparam int NTONES = OCTAVES * SEMIS_PER_OCT;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic       changed;
    logic [5:0] count;
    logic [5:0] tone;
    logic       sel;
    logic [6:0] pitch;
  } tone_pick_t;

  logic [NTONES-1:0] tone_on;
  logic [6:0]        prev_pitch;
  logic [1:0]        span_mode;
  tone_pick_t        pick_q[$];

  // Applies the request's action to the tone set, then quantizes the position.
  function automatic tone_pick_t quantize_tone(input logic [26:0] req);
    tone_pick_t        res;
    logic [1:0]        act;
    logic signed [7:0] tt;
    logic [11:0]       pos;
    logic              present;
    logic [3:0]        base;
    int                lo, hi, cnt, target, seen, i, sel_idx;
    act = req[1:0];
    tt = req[9:2];
    pos = req[21:10];
    present = req[22];
    base = req[26:23];
    if (act == ACT_TOGGLE) begin
      if (tt >= 0 && int'(tt) < NTONES) tone_on[int'(tt)] = ~tone_on[int'(tt)];
    end else if (act == ACT_CLEAR) begin
      tone_on = '0;
    end
    case (span_mode)
      RANGE_ALL: begin
        lo = 0;
        hi = NTONES - 1;
      end
      RANGE_INNER: begin
        lo = SEMIS_PER_OCT;
        hi = NTONES - SEMIS_PER_OCT - 1;
      end
      default: begin
        lo = 2 * SEMIS_PER_OCT;
        hi = NTONES - 2 * SEMIS_PER_OCT - 1;
      end
    endcase
    cnt = 0;
    for (i = lo; i <= hi; i++) begin
      if (tone_on[i]) cnt++;
    end
    if (base > MAX_BASE) base = MAX_BASE;
    res = '0;
    sel_idx = 0;
    if (present && cnt > 0) begin
      target = (cnt * int'(pos)) >> 12;
      seen = 0;
      for (i = lo; i <= hi; i++) begin
        if (tone_on[i]) begin
          if (seen == target) begin
            res.sel = 1'b1;
            sel_idx = i;
            break;
          end
          seen++;
        end
      end
    end
    res.tone = 6'(sel_idx);
    res.pitch = res.sel ? 7'(sel_idx + int'(base)) : NO_SEL_PITCH;
    res.count = (cnt > 63) ? 6'd63 : 6'(cnt);
    res.changed = (res.pitch != prev_pitch);
    prev_pitch = res.pitch;
    return res;
  endfunction

  task automatic log_failure(input string what, input tone_pick_t want, input tone_pick_t got);
    if (errors < MAX_REPORTS) begin
      $display("%0t %s: pitch %0d/%0d sel %0d/%0d tone %0d/%0d count %0d/%0d changed %0d/%0d",
               $realtime, what, want.pitch, got.pitch, want.sel, got.sel, want.tone, got.tone,
               want.count, got.count, want.changed, got.changed);
    end
    errors++;
  endtask

  always @(posedge clk) begin
    tone_pick_t got, want;
    if (rst) begin
      tone_on = '0;
      prev_pitch = LAST_PITCH_RST;
      span_mode = RANGE_ALL;
      pick_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) span_mode = cfg_wdata;
      if (s_tvalid && s_tready) pick_q.insert(pick_q.size(), quantize_tone(s_tdata[26:0]));
      if (m_tvalid && m_tready) begin
        got = tone_pick_t'(m_tdata[20:0]);
        if (pick_q.size() == 0) begin
          log_failure("unexpected result (none/actual)", '0, got);
        end else begin
          want = pick_q.pop_front();
          if (got.pitch !== want.pitch || got.sel !== want.sel || got.tone !== want.tone ||
              got.count !== want.count || got.changed !== want.changed) begin
            log_failure("result mismatch (expected/actual)", want, got);
          end
        end
      end
    end
    pending = pick_q.size();
  end

endmodule

### bench/tb_scale_tone_selector_top.sv
// Testbench top for scale_tone_selector_top: clock, reset, range writes, request and
// result stream drivers with random stalls, watchdog and verdict. Depends on stsel_pkg,
// the DUT and stsel_checker.
module tb_scale_tone_selector_top;
  timeunit 1ns;
  timeprecision 1ps;
  import stsel_pkg::*;

  localparam int NTONES = DEF_OCTAVES * SEMIS_PER_OCT;
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam logic [1:0] RANGE_MID = 2'd2;
  localparam logic [1:0] RANGE_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 150;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 50;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        quiet = 1'b0;
  int          errors;
  int          pending;
  int          idle_cycles = 0;

  always #10 clk = ~clk;

  scale_tone_selector_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  stsel_checker i_check (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (errors),
    .pending  (pending)
  );

  // mostly no gap, some short ones, a few long
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] pack_request(input logic [1:0] act, input int tone,
                                               input int pos, input logic present,
                                               input int base);
    logic [7:0] tone_bits;
    logic [11:0] pos_bits;
    logic [3:0] base_bits;
    tone_bits = tone[7:0];
    pos_bits = pos[11:0];
    base_bits = base[3:0];
    return {5'd0, base_bits, present, pos_bits, tone_bits, act};
  endfunction

  function automatic logic [31:0] random_request();
    int r, tone, pos;
    logic [1:0] act;
    r = $urandom_range(0, 99);
    tone = $urandom_range(0, NTONES - 1);
    if (r < 45) begin
      act = ACT_TOGGLE;
    end else if (r < 52) begin
      act = ACT_TOGGLE;
      tone = $urandom_range(0, 1) ? $urandom_range(NTONES, 127) : -$urandom_range(1, 128);
    end else if (r < 55) begin
      act = ACT_CLEAR;
    end else if (r < 60) begin
      act = ACT_SPARE;
      tone = $urandom_range(0, 255);
    end else begin
      act = ACT_SAMPLE;
      tone = $urandom_range(0, 255);
    end
    r = $urandom_range(0, 99);
    pos = (r < 10) ? 0 : (r < 20) ? 4095 : $urandom_range(0, 4095);
    return pack_request(act, tone, pos, $urandom_range(0, 9) != 0, $urandom_range(0, 15));
  endfunction

  // entered and left at a falling edge
  task automatic send_request(input logic [31:0] req);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= req;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic wait_results();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_range(input logic [1:0] mode);
    wait_results();
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int bound_tones[8] = '{11, 12, 23, 24, 35, 36, 47, 48};
    logic [1:0] mode;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_range(RANGE_ALL);
    send_request(pack_request(ACT_SAMPLE, 0, 2048, 1'b1, 0));
    send_request(pack_request(ACT_TOGGLE, 0, 0, 1'b1, 0));
    send_request(pack_request(ACT_TOGGLE, NTONES - 1, 4095, 1'b1, 11));
    send_request(pack_request(ACT_TOGGLE, -128, 4095, 1'b1, 15));
    send_request(pack_request(ACT_TOGGLE, 127, 4095, 1'b1, 12));
    send_request(pack_request(ACT_TOGGLE, NTONES, 2048, 1'b1, 3));
    send_request(pack_request(ACT_TOGGLE, -1, 2048, 1'b0, 3));
    send_request(pack_request(ACT_SPARE, 85, 0, 1'b1, 5));
    foreach (bound_tones[k])
      send_request(pack_request(ACT_TOGGLE, bound_tones[k], $urandom_range(0, 4095), 1'b1, 0));
    send_request(pack_request(ACT_SAMPLE, 0, 4095, 1'b1, 0));
    write_range(RANGE_MID);
    send_request(pack_request(ACT_SAMPLE, 0, 0, 1'b1, 0));
    send_request(pack_request(ACT_SAMPLE, 0, 4095, 1'b1, 11));
    write_range(RANGE_SPARE);
    send_request(pack_request(ACT_SAMPLE, 0, 2048, 1'b1, 1));
    write_range(RANGE_INNER);
    send_request(pack_request(ACT_SAMPLE, 0, 0, 1'b1, 2));
    send_request(pack_request(ACT_SAMPLE, 0, 4095, 1'b1, 13));
    send_request(pack_request(ACT_CLEAR, 0, 4095, 1'b1, 0));
    send_request(pack_request(ACT_TOGGLE, 0, 1000, 1'b1, 7));

    for (int ph = 0; ph < PHASES; ph++) begin
      mode = (ph < 4) ? 2'(ph) : 2'($urandom_range(0, 3));
      write_range(mode);
      quiet = (ph == 2);
      repeat (PHASE_ITEMS) send_request(random_request());
      quiet = 1'b0;
    end

    wait_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("** scale_tone_selector_top: PASSED **");
    end else begin
      $display("** scale_tone_selector_top: FAILED **");
    end
    $finish;
  end

  initial begin
    int gap;
    forever begin
      @(negedge clk);
      m_tready <= 1'b1;
      repeat ($urandom_range(0, 7)) @(negedge clk);
      gap = idle_gap();
      if (gap > 0) begin
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("** scale_tone_selector_top: FAILED **");
        $finish;
      end
    end
  end

endmodule
